// ===== hw/rtl/eeg_pkg.sv =====
package eeg_pkg;

  localparam int OPND_W = 32;
  localparam int COEF_W = 33;
  localparam int PC_W   = 4;

  typedef logic [PC_W-1:0] pc_t;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_LOAD,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_SHIFT_UV,
    OP_UPD_COEF,
    OP_EMIT,
    OP_SET_UNIT
  } op_t;

  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_INPUT,
    C_V_ZERO,
    C_CNT_MORE,
    C_REM_ZERO,
    C_OUT_BUSY
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    pc_t   target;
  } uword_t;

  typedef struct packed {
    logic in_valid;
    logic out_busy;
    logic v_zero;
    logic rem_zero;
    logic cnt_more;
  } status_t;

  localparam pc_t A_LOAD     = pc_t'(0);
  localparam pc_t A_CHECK    = pc_t'(1);
  localparam pc_t A_DIV_INIT = pc_t'(2);
  localparam pc_t A_DIV_STEP = pc_t'(3);
  localparam pc_t A_SHIFT    = pc_t'(4);
  localparam pc_t A_UPD      = pc_t'(5);
  localparam pc_t A_EMIT     = pc_t'(6);
  localparam pc_t A_RET      = pc_t'(7);
  localparam pc_t A_UNIT     = pc_t'(8);
  localparam pc_t A_LAST     = A_UNIT;

  // microprogram: a jump is taken when its condition holds, else fall through
  function automatic uword_t urom(pc_t pc);
    uword_t w;
    unique case (pc)
      A_LOAD:     w = '{OP_LOAD,     C_NO_INPUT, A_LOAD};
      A_CHECK:    w = '{OP_NOP,      C_V_ZERO,   A_UNIT};
      A_DIV_INIT: w = '{OP_DIV_INIT, C_NEVER,    A_LOAD};
      A_DIV_STEP: w = '{OP_DIV_STEP, C_CNT_MORE, A_DIV_STEP};
      A_SHIFT:    w = '{OP_SHIFT_UV, C_REM_ZERO, A_EMIT};
      A_UPD:      w = '{OP_UPD_COEF, C_ALWAYS,   A_DIV_INIT};
      A_EMIT:     w = '{OP_EMIT,     C_OUT_BUSY, A_EMIT};
      A_RET:      w = '{OP_NOP,      C_ALWAYS,   A_LOAD};
      A_UNIT:     w = '{OP_SET_UNIT, C_ALWAYS,   A_EMIT};
      default:    w = '{OP_NOP,      C_ALWAYS,   A_LOAD};
    endcase
    return w;
  endfunction

endpackage

// ===== hw/rtl/eeg_seq.sv =====
module eeg_seq (
  input  logic             clk,
  input  logic             rst,
  input  eeg_pkg::status_t status,
  output eeg_pkg::uword_t  uword
);

  eeg_pkg::pc_t pc;
  eeg_pkg::pc_t pc_next;
  logic         take;

  always_comb begin
    uword = eeg_pkg::urom(pc);
    unique case (uword.cond)
      eeg_pkg::C_NEVER:    take = 1'b0;
      eeg_pkg::C_ALWAYS:   take = 1'b1;
      eeg_pkg::C_NO_INPUT: take = !status.in_valid;
      eeg_pkg::C_V_ZERO:   take = status.v_zero;
      eeg_pkg::C_CNT_MORE: take = status.cnt_more;
      eeg_pkg::C_REM_ZERO: take = status.rem_zero;
      eeg_pkg::C_OUT_BUSY: take = status.out_busy;
      default:             take = 1'b1;
    endcase
    pc_next = take ? uword.target : pc + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= eeg_pkg::A_LOAD;
    end else begin
      pc <= pc_next;
    end
  end

  a_pc_range: assert property (@(posedge clk) disable iff (rst) pc <= eeg_pkg::A_LAST)
    else $error("step counter outside program");

endmodule

// ===== hw/rtl/eeg_dp.sv =====
module eeg_dp #(
  parameter int WIDTH = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  eeg_pkg::op_t                        op,
  input  logic                                in_valid,
  input  logic        [eeg_pkg::OPND_W-1:0]   a_value,
  input  logic        [eeg_pkg::OPND_W-1:0]   b_value,
  input  logic                                out_stall,
  output logic                                out_valid,
  output logic        [eeg_pkg::OPND_W-1:0]   gcd_value,
  output logic signed [eeg_pkg::COEF_W-1:0]   coef_a,
  output logic signed [eeg_pkg::COEF_W-1:0]   coef_b,
  output eeg_pkg::status_t                    status
);

  localparam int CW  = WIDTH + 1;
  localparam int CNT_W = $clog2(WIDTH + 1);

  logic [WIDTH-1:0] u;
  logic [WIDTH-1:0] v_reg;
  logic [WIDTH-1:0] rem;
  logic [WIDTH-1:0] dvd;
  logic [CNT_W-1:0] cnt;
  logic [CW-1:0]    cur_x;
  logic [CW-1:0]    cur_y;
  logic [CW-1:0]    prev_x;
  logic [CW-1:0]    prev_y;
  logic [CW-1:0]    acc_x;
  logic [CW-1:0]    acc_y;

  logic [WIDTH+eeg_pkg::OPND_W-1:0] a_ext;
  logic [WIDTH+eeg_pkg::OPND_W-1:0] b_ext;
  logic [WIDTH+eeg_pkg::OPND_W-1:0] g_ext;
  logic [CW+eeg_pkg::COEF_W-1:0]    cx_ext;
  logic [CW+eeg_pkg::COEF_W-1:0]    cy_ext;
  logic [WIDTH:0]   rem_sh;
  logic [WIDTH+1:0] diff;
  logic             qbit;
  logic [CW-1:0]    acc_x_next;
  logic [CW-1:0]    acc_y_next;
  logic             out_busy;

  always_comb begin
    a_ext  = {{WIDTH{1'b0}}, a_value};
    b_ext  = {{WIDTH{1'b0}}, b_value};
    g_ext  = {{eeg_pkg::OPND_W{1'b0}}, u};
    cx_ext = {{eeg_pkg::COEF_W{1'b0}}, cur_x};
    cy_ext = {{eeg_pkg::COEF_W{1'b0}}, cur_y};
    // restoring division step; quotient bit also drives cur*q by Horner shift-add
    rem_sh = {rem, dvd[WIDTH-1]};
    diff   = {1'b0, rem_sh} - {2'b00, v_reg};
    qbit   = !diff[WIDTH+1];
    acc_x_next = {acc_x[CW-2:0], 1'b0} + (qbit ? cur_x : '0);
    acc_y_next = {acc_y[CW-2:0], 1'b0} + (qbit ? cur_y : '0);
    out_busy = out_valid && out_stall;
    status.in_valid = in_valid;
    status.out_busy = out_busy;
    status.v_zero   = (v_reg == '0);
    status.rem_zero = (rem == '0);
    status.cnt_more = (cnt != CNT_W'(1));
  end

  always_ff @(posedge clk) begin
    unique case (op)
      eeg_pkg::OP_LOAD: begin
        if (in_valid) begin
          u      <= a_ext[WIDTH-1:0];
          v_reg  <= b_ext[WIDTH-1:0];
          cur_x  <= '0;
          cur_y  <= CW'(1);
          prev_x <= CW'(1);
          prev_y <= '0;
        end
      end
      eeg_pkg::OP_DIV_INIT: begin
        rem   <= '0;
        dvd   <= u;
        cnt   <= CNT_W'(WIDTH);
        acc_x <= '0;
        acc_y <= '0;
      end
      eeg_pkg::OP_DIV_STEP: begin
        rem   <= qbit ? diff[WIDTH-1:0] : rem_sh[WIDTH-1:0];
        dvd   <= {dvd[WIDTH-2:0], 1'b0};
        cnt   <= cnt - 1'b1;
        acc_x <= acc_x_next;
        acc_y <= acc_y_next;
      end
      eeg_pkg::OP_SHIFT_UV: begin
        u     <= v_reg;
        v_reg <= rem;
      end
      eeg_pkg::OP_UPD_COEF: begin
        cur_x  <= prev_x - acc_x;
        cur_y  <= prev_y - acc_y;
        prev_x <= cur_x;
        prev_y <= cur_y;
      end
      eeg_pkg::OP_SET_UNIT: begin
        cur_x <= CW'(1);
        cur_y <= '0;
      end
      eeg_pkg::OP_EMIT: begin
        if (!out_busy) begin
          gcd_value <= g_ext[eeg_pkg::OPND_W-1:0];
          coef_a    <= signed'(cx_ext[eeg_pkg::COEF_W-1:0]);
          coef_b    <= signed'(cy_ext[eeg_pkg::COEF_W-1:0]);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (op == eeg_pkg::OP_EMIT && !out_busy) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (rst)
    op == eeg_pkg::OP_DIV_STEP |-> rem < v_reg)
    else $error("partial remainder not below divisor");

  a_upd_nonzero_divisor: assert property (@(posedge clk) disable iff (rst)
    op == eeg_pkg::OP_UPD_COEF |-> v_reg != '0)
    else $error("coefficient update with zero remainder");

endmodule

// ===== hw/rtl/extended_euclid_gcd.sv =====
// channel  direction  handshake             fields
// in       to block   in_valid / in_stall   a_value, b_value
// out      from block out_valid / out_stall gcd_value, coef_a, coef_b
//
// One item at a time; each Euclid step runs on the shared radix-2 divider
// (one quotient bit per cycle). About 46 steps worst case at WIDTH=32.
// Reset clears the step counter and out_valid only.
// A stalled result holds the program at its emit step; the next item is
// taken once the result is registered.
module extended_euclid_gcd #(
  parameter int WIDTH = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic        [eeg_pkg::OPND_W-1:0] a_value,
  input  logic        [eeg_pkg::OPND_W-1:0] b_value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic        [eeg_pkg::OPND_W-1:0] gcd_value,
  output logic signed [eeg_pkg::COEF_W-1:0] coef_a,
  output logic signed [eeg_pkg::COEF_W-1:0] coef_b
);

  eeg_pkg::uword_t  uword;
  eeg_pkg::status_t status;

  eeg_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .uword  (uword)
  );

  eeg_dp #(
    .WIDTH (WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .op        (uword.op),
    .in_valid  (in_valid),
    .a_value   (a_value),
    .b_value   (b_value),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .gcd_value (gcd_value),
    .coef_a    (coef_a),
    .coef_b    (coef_b),
    .status    (status)
  );

  assign in_stall = (uword.op != eeg_pkg::OP_LOAD);

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("item taken while previous item in progress");

endmodule
